// File: sv/pmpf_pkg.sv
// pmpf_pkg: shared types, codes and helpers for the prefix match packet filter.
// Used by pmpf_cfg_regs, pmpf_cell and prefix_match_packet_filter.
package pmpf_pkg;

	localparam logic [1:0] OP_PACKET   = 2'd0;
	localparam logic [1:0] OP_WR_V4    = 2'd1;
	localparam logic [1:0] OP_WR_V6_HI = 2'd2;
	localparam logic [1:0] OP_WR_V6_LO = 2'd3;

	localparam logic [3:0] VER_V4 = 4'd4;
	localparam logic [3:0] VER_V6 = 4'd6;

	localparam logic [7:0] PREFIX_MAX = 8'd128;

	// register index, taken from paddr[2]
	localparam logic REG_V4_CNT = 1'b0;
	localparam logic REG_V6_CNT = 1'b1;

	localparam int CNT_W  = 4;
	localparam int ADDR_W = 3;

	typedef struct packed {
		logic [CNT_W-1:0] v4_cnt;
		logic [CNT_W-1:0] v6_cnt;
	} cfg_t;

	// one beat travelling down the cell chain
	typedef struct packed {
		logic [1:0]  opcode;
		logic        is_pkt;    // packet of version 4 or 6
		logic        is_v6;
		logic        src_hit;
		logic        dst_hit;
		logic [31:0] uid;
		logic [15:0] length;
		logic        dir;
		logic [63:0] src_high;
		logic [63:0] src_low;
		logic [63:0] dst_high;
		logic [63:0] dst_low;
		logic [2:0]  entry_index;
		logic [63:0] entry_word;
		logic [7:0]  entry_prefix_len;
	} beat_t;

	// leading-ones mask of a 128-bit address, prefix clamped at 128
	function automatic logic [127:0] lead_mask(input logic [7:0] plen);
		logic [7:0] p;
		p = (plen > PREFIX_MAX) ? PREFIX_MAX : plen;
		lead_mask = {128{1'b1}} << (PREFIX_MAX - p);
	endfunction

endpackage

// File: sv/pmpf_cfg_regs.sv
// pmpf_cfg_regs: APB-style register file holding the entry-in-use counts.
// Depends on pmpf_pkg.
module pmpf_cfg_regs (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [pmpf_pkg::ADDR_W-1:0]  paddr,
	input  logic [31:0]                  pwdata,
	output logic [31:0]                  prdata,
	output logic                         pready,
	output pmpf_pkg::cfg_t               cfg
);
	import pmpf_pkg::*;

	logic   wr_en;
	cfg_t   cfg_q;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (wr_en) begin
			case (paddr[2])
				REG_V4_CNT: cfg_q.v4_cnt <= pwdata[CNT_W-1:0];
				REG_V6_CNT: cfg_q.v6_cnt <= pwdata[CNT_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[2])
			REG_V4_CNT: prdata = {{(32-CNT_W){1'b0}}, cfg_q.v4_cnt};
			REG_V6_CNT: prdata = {{(32-CNT_W){1'b0}}, cfg_q.v6_cnt};
			default:    prdata = '0;
		endcase
	end

	assign cfg = cfg_q;

endmodule

// File: sv/pmpf_cell.sv
// pmpf_cell: one table slot of the chain; holds IPv4 and IPv6 entry IDX,
// updates it from passing write beats and marks hits on passing packets.
// Depends on pmpf_pkg.
module pmpf_cell #(
	parameter int IDX        = 0,
	parameter int V4_ENTRIES = 8,
	parameter int V6_ENTRIES = 8
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              en,
	input  pmpf_pkg::cfg_t    cfg,
	input  logic              up_valid,
	input  pmpf_pkg::beat_t   up_beat,
	output logic              dn_valid,
	output pmpf_pkg::beat_t   dn_beat
);
	import pmpf_pkg::*;

	localparam bit HAS_V4 = (IDX < V4_ENTRIES);
	localparam bit HAS_V6 = (IDX < V6_ENTRIES);

	// entry storage, undefined until written
	logic [63:0]  v4_word_q;
	logic [63:0]  v6_hi_q;
	logic [63:0]  v6_lo_q;
	logic [127:0] v6_mask_q;

	logic  idx_hit;
	logic  v4_act, v6_act;
	logic  h4_src, h4_dst, h6_src, h6_dst;
	logic  valid_q;
	beat_t beat_q;
	beat_t beat_nx;

	assign idx_hit = (32'(up_beat.entry_index) == 32'(IDX));
	assign v4_act  = HAS_V4 && (32'(cfg.v4_cnt) > 32'(IDX));
	assign v6_act  = HAS_V6 && (32'(cfg.v6_cnt) > 32'(IDX));

	assign h4_src = v4_act && ((up_beat.src_low[31:0] & v4_word_q[63:32]) == v4_word_q[31:0]);
	assign h4_dst = v4_act && ((up_beat.dst_low[31:0] & v4_word_q[63:32]) == v4_word_q[31:0]);

	assign h6_src = v6_act
		&& (((up_beat.src_high ^ v6_hi_q) & v6_mask_q[127:64]) == '0)
		&& (((up_beat.src_low  ^ v6_lo_q) & v6_mask_q[63:0])   == '0);
	assign h6_dst = v6_act
		&& (((up_beat.dst_high ^ v6_hi_q) & v6_mask_q[127:64]) == '0)
		&& (((up_beat.dst_low  ^ v6_lo_q) & v6_mask_q[63:0])   == '0);

	always_comb begin
		beat_nx = up_beat;
		if (up_beat.is_pkt) begin
			beat_nx.src_hit = up_beat.src_hit | (up_beat.is_v6 ? h6_src : h4_src);
			beat_nx.dst_hit = up_beat.dst_hit | (up_beat.is_v6 ? h6_dst : h4_dst);
		end
	end

	// table writes land when the write beat passes this slot
	always_ff @(posedge clk) begin
		if (en && up_valid && idx_hit) begin
			case (up_beat.opcode)
				OP_WR_V4: begin
					if (HAS_V4) v4_word_q <= up_beat.entry_word;
				end
				OP_WR_V6_HI: begin
					if (HAS_V6) begin
						v6_hi_q   <= up_beat.entry_word;
						v6_mask_q <= lead_mask(up_beat.entry_prefix_len);
					end
				end
				OP_WR_V6_LO: begin
					if (HAS_V6) v6_lo_q <= up_beat.entry_word;
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (en) begin
			valid_q <= up_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			beat_q <= beat_nx;
		end
	end

	assign dn_valid = valid_q;
	assign dn_beat  = beat_q;

endmodule

// File: sv/prefix_match_packet_filter.sv
// prefix_match_packet_filter: CIDR exclusion filter over packet metadata.
// Every beat is registered in each cell of the chain in turn, and the last cell's register
//   drives the event channel.
//   Throughput: one beat per cycle while out_stall is low.
// A stalled event freezes the whole chain, so in_stall follows it.
// Reset clears beat valids and both count registers; table entries are undefined until written.
module prefix_match_packet_filter #(
	parameter int V4_TABLE_ENTRIES = 8,
	parameter int V6_TABLE_ENTRIES = 8
) (
	input  logic                          clk,
	input  logic                          arst_n,

	// config port
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [pmpf_pkg::ADDR_W-1:0]   paddr,
	input  logic [31:0]                   pwdata,
	output logic [31:0]                   prdata,
	output logic                          pready,

	// input channel
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [1:0]                    opcode,
	input  logic [7:0]                    first_header_byte,
	input  logic [31:0]                   socket_uid,
	input  logic [15:0]                   packet_length,
	input  logic                          direction,
	input  logic [63:0]                   src_high,
	input  logic [63:0]                   src_low,
	input  logic [63:0]                   dst_high,
	input  logic [63:0]                   dst_low,
	input  logic [2:0]                    entry_index,
	input  logic [63:0]                   entry_word,
	input  logic [7:0]                    entry_prefix_len,

	// event channel
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic                          is_v6,
	output logic [31:0]                   event_uid,
	output logic [15:0]                   event_bytes,
	output logic                          event_direction,
	output logic [63:0]                   event_src_high,
	output logic [63:0]                   event_src_low,
	output logic [63:0]                   event_dst_high,
	output logic [63:0]                   event_dst_low
);
	import pmpf_pkg::*;

	// one cell per table slot; a slot holds an entry of each table that reaches it
	localparam int NCELLS = (V4_TABLE_ENTRIES > V6_TABLE_ENTRIES) ?
		V4_TABLE_ENTRIES : V6_TABLE_ENTRIES;

	cfg_t              cfg;
	logic              en;
	logic [3:0]        ver;
	logic              pkt_v4, pkt_v6;
	logic [NCELLS:0]   chain_valid;
	beat_t             chain_beat [NCELLS+1];
	beat_t             tail;

	pmpf_cfg_regs u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// chain moves as a whole unless the finished event is held off
	assign en       = !(out_valid && out_stall);
	assign in_stall = !en;

	// head of the chain: classify the beat and clean up IPv4 addresses
	assign ver    = first_header_byte[7:4];
	assign pkt_v4 = (opcode == OP_PACKET) && (ver == VER_V4);
	assign pkt_v6 = (opcode == OP_PACKET) && (ver == VER_V6);

	assign chain_valid[0] = in_valid;

	always_comb begin
		chain_beat[0].opcode           = opcode;
		chain_beat[0].is_pkt           = pkt_v4 || pkt_v6;
		chain_beat[0].is_v6            = pkt_v6;
		chain_beat[0].src_hit          = 1'b0;
		chain_beat[0].dst_hit          = 1'b0;
		chain_beat[0].uid              = socket_uid;
		chain_beat[0].length           = packet_length;
		chain_beat[0].dir              = direction;
		chain_beat[0].entry_index      = entry_index;
		chain_beat[0].entry_word       = entry_word;
		chain_beat[0].entry_prefix_len = entry_prefix_len;
		if (pkt_v6) begin
			chain_beat[0].src_high = src_high;
			chain_beat[0].src_low  = src_low;
			chain_beat[0].dst_high = dst_high;
			chain_beat[0].dst_low  = dst_low;
		end else begin
			// every beat but IPv6: only the low 32 bits of each address count
			chain_beat[0].src_high = '0;
			chain_beat[0].src_low  = {32'd0, src_low[31:0]};
			chain_beat[0].dst_high = '0;
			chain_beat[0].dst_low  = {32'd0, dst_low[31:0]};
		end
	end

	// write beats travel with packets, so every packet sees the table
	// exactly as it stood when the packet was accepted
	for (genvar i = 0; i < NCELLS; i++) begin : g_cell
		pmpf_cell #(
			.IDX        (i),
			.V4_ENTRIES (V4_TABLE_ENTRIES),
			.V6_ENTRIES (V6_TABLE_ENTRIES)
		) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.en       (en),
			.cfg      (cfg),
			.up_valid (chain_valid[i]),
			.up_beat  (chain_beat[i]),
			.dn_valid (chain_valid[i+1]),
			.dn_beat  (chain_beat[i+1])
		);
	end

	// tail of the chain doubles as the output register; writes, other
	// versions and packets hit on both addresses simply fall out here
	assign tail      = chain_beat[NCELLS];
	assign out_valid = chain_valid[NCELLS] && tail.is_pkt && !(tail.src_hit && tail.dst_hit);

	assign is_v6           = tail.is_v6;
	assign event_uid       = tail.uid;
	assign event_bytes     = tail.length;
	assign event_direction = tail.dir;
	assign event_src_high  = tail.src_high;
	assign event_src_low   = tail.src_low;
	assign event_dst_high  = tail.dst_high;
	assign event_dst_low   = tail.dst_low;

	// a held event freezes every beat slot in the chain
	a_chain_frozen: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |=> $stable(chain_valid[NCELLS:1]))
		else $error("chain moved while stalled");

	// IPv4 events carry only 32-bit addresses
	a_v4_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !is_v6) |-> (event_src_high == '0 && event_dst_high == '0
			&& event_src_low[63:32] == '0 && event_dst_low[63:32] == '0))
		else $error("IPv4 event with upper address bits set");

	// an IPv4 count write shows up in the chain's view of the config
	a_cnt_write: assert property (@(posedge clk) disable iff (!arst_n)
		(psel && penable && pwrite && (paddr[2] == REG_V4_CNT))
			|=> (cfg.v4_cnt == $past(pwdata[CNT_W-1:0])))
		else $error("IPv4 count write lost");

endmodule

// File: tb/tb.sv
// tb: self-checking testbench for prefix_match_packet_filter.
// Loads the exclusion tables, walks the entry counts through several settings and
// checks every metered event against an in-order prediction; needs only pmpf_pkg and the RTL.
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import pmpf_pkg::*;

	localparam int TABLE_DEPTH    = 8;      // entries per table in the instance below
	localparam int LATENCY        = 8;      // one chain cell per entry, deepest table wins
	localparam int DRAIN_CYCLES   = LATENCY + 4;
	localparam int RESET_CYCLES   = 8;
	localparam int WATCHDOG_LIMIT = 1000;   // quiet cycles allowed before the bench fails
	localparam int RANDOM_PHASES  = 8;
	localparam int PHASE_ITEMS    = 210;    // counted beats per random phase
	localparam int MAX_REPORTS    = 40;

	// one input beat, field for field as on the ports
	typedef struct packed {
		logic [1:0]  opcode;
		logic [7:0]  first_header_byte;
		logic [31:0] socket_uid;
		logic [15:0] packet_length;
		logic        direction;
		logic [63:0] src_high;
		logic [63:0] src_low;
		logic [63:0] dst_high;
		logic [63:0] dst_low;
		logic [2:0]  entry_index;
		logic [63:0] entry_word;
		logic [7:0]  entry_prefix_len;
	} pkt_item_t;

	// one metered event on the output channel
	typedef struct packed {
		logic        is_v6;
		logic [31:0] uid;
		logic [15:0] bytes;
		logic        dir;
		logic [63:0] src_high;
		logic [63:0] src_low;
		logic [63:0] dst_high;
		logic [63:0] dst_low;
	} meter_event_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	// config port, driven only while the filter is idle
	logic              psel = 1'b0;
	logic              penable = 1'b0;
	logic              pwrite = 1'b0;
	logic [ADDR_W-1:0] paddr = '0;
	logic [31:0]       pwdata = '0;
	logic [31:0]       prdata;
	logic              pready;

	// input channel; the payload is held in one struct register
	logic      in_valid = 1'b0;
	logic      in_stall;
	pkt_item_t cur = '0;

	// event channel
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic        is_v6;
	logic [31:0] event_uid;
	logic [15:0] event_bytes;
	logic        event_direction;
	logic [63:0] event_src_high;
	logic [63:0] event_src_low;
	logic [63:0] event_dst_high;
	logic [63:0] event_dst_low;

	prefix_match_packet_filter #(
		.V4_TABLE_ENTRIES(TABLE_DEPTH),
		.V6_TABLE_ENTRIES(TABLE_DEPTH)
	) DUT (
		.clk              (clk),
		.arst_n           (arst_n),
		.psel             (psel),
		.penable          (penable),
		.pwrite           (pwrite),
		.paddr            (paddr),
		.pwdata           (pwdata),
		.prdata           (prdata),
		.pready           (pready),
		.in_valid         (in_valid),
		.in_stall         (in_stall),
		.opcode           (cur.opcode),
		.first_header_byte(cur.first_header_byte),
		.socket_uid       (cur.socket_uid),
		.packet_length    (cur.packet_length),
		.direction        (cur.direction),
		.src_high         (cur.src_high),
		.src_low          (cur.src_low),
		.dst_high         (cur.dst_high),
		.dst_low          (cur.dst_low),
		.entry_index      (cur.entry_index),
		.entry_word       (cur.entry_word),
		.entry_prefix_len (cur.entry_prefix_len),
		.out_valid        (out_valid),
		.out_stall        (out_stall),
		.is_v6            (is_v6),
		.event_uid        (event_uid),
		.event_bytes      (event_bytes),
		.event_direction  (event_direction),
		.event_src_high   (event_src_high),
		.event_src_low    (event_src_low),
		.event_dst_high   (event_dst_high),
		.event_dst_low    (event_dst_low)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	pkt_item_t    beats_to_send[$];
	meter_event_t due_events[$];
	int           mismatches = 0;
	int           real_items = 0;   // writes plus IPv4/IPv6 packets queued so far
	bit           in_gaps_on = 1'b1;
	bit           out_stalls_on = 1'b1;

	// ------------------------------------------------------------------
	// Filter shadow: tables and counts as the block should hold them,
	// advanced beat by beat in acceptance order.
	// ------------------------------------------------------------------
	logic [63:0] flt_v4_rule [TABLE_DEPTH];   // mask in [63:32], net in [31:0]
	logic [63:0] flt_v6_hi   [TABLE_DEPTH];
	logic [63:0] flt_v6_lo   [TABLE_DEPTH];
	logic [7:0]  flt_v6_plen [TABLE_DEPTH];
	logic [CNT_W-1:0] flt_v4_cnt = '0;
	logic [CNT_W-1:0] flt_v6_cnt = '0;

	// Stimulus-side copy of the same tables, advanced as beats are queued,
	// so that generated addresses can be aimed at live entries.
	logic [63:0] gen_v4_rule [TABLE_DEPTH];
	logic [63:0] gen_v6_hi   [TABLE_DEPTH];
	logic [63:0] gen_v6_lo   [TABLE_DEPTH];
	logic [7:0]  gen_v6_plen [TABLE_DEPTH];
	logic [CNT_W-1:0] gen_v4_cnt = '0;
	logic [CNT_W-1:0] gen_v6_cnt = '0;

	// counts above the table depth search the whole table
	function automatic int searched(input logic [CNT_W-1:0] cnt);
		return (cnt > TABLE_DEPTH) ? TABLE_DEPTH : int'(cnt);
	endfunction

	// leading-ones mask; prefix lengths past 128 behave as 128
	function automatic logic [127:0] prefix_mask(input logic [7:0] plen);
		int unsigned p;
		p = (plen > 8'd128) ? 128 : plen;
		return ~({128{1'b1}} >> p);
	endfunction

	function automatic bit v4_excluded(input logic [31:0] addr);
		for (int i = 0; i < searched(flt_v4_cnt); i++)
			if ((addr & flt_v4_rule[i][63:32]) == flt_v4_rule[i][31:0])
				return 1'b1;
		return 1'b0;
	endfunction

	function automatic bit v6_excluded(input logic [127:0] addr);
		for (int i = 0; i < searched(flt_v6_cnt); i++)
			if (((addr ^ {flt_v6_hi[i], flt_v6_lo[i]}) & prefix_mask(flt_v6_plen[i])) == '0)
				return 1'b1;
		return 1'b0;
	endfunction

	// Apply one accepted beat: writes update the tables, packets may meter an event.
	// Other versions never meter; a v4/v6 packet drops only with both ends in its version's set.
	function automatic void filter_beat(input pkt_item_t b);
		meter_event_t ev;
		logic [3:0]   ver;
		ver = b.first_header_byte[7:4];
		ev = '0;
		ev.uid = b.socket_uid;
		ev.bytes = b.packet_length;
		ev.dir = b.direction;
		case (b.opcode)
			OP_WR_V4: begin
				flt_v4_rule[b.entry_index] = b.entry_word;
			end
			OP_WR_V6_HI: begin
				flt_v6_hi[b.entry_index] = b.entry_word;
				flt_v6_plen[b.entry_index] = b.entry_prefix_len;
			end
			OP_WR_V6_LO: begin
				flt_v6_lo[b.entry_index] = b.entry_word;
			end
			default: begin
				if (ver == VER_V4) begin
					// IPv4 uses only the low 32 bits of each low half
					if (!(v4_excluded(b.src_low[31:0]) && v4_excluded(b.dst_low[31:0]))) begin
						ev.is_v6 = 1'b0;
						ev.src_low = {32'h0, b.src_low[31:0]};
						ev.dst_low = {32'h0, b.dst_low[31:0]};
						due_events.push_back(ev);
					end
				end else if (ver == VER_V6) begin
					if (!(v6_excluded({b.src_high, b.src_low}) &&
					      v6_excluded({b.dst_high, b.dst_low}))) begin
						ev.is_v6 = 1'b1;
						ev.src_high = b.src_high;
						ev.src_low = b.src_low;
						ev.dst_high = b.dst_high;
						ev.dst_low = b.dst_low;
						due_events.push_back(ev);
					end
				end
			end
		endcase
	endfunction

	// ------------------------------------------------------------------
	// Stimulus construction
	// ------------------------------------------------------------------
	function automatic logic [63:0] rand64();
		return {$urandom, $urandom};
	endfunction

	// every field random, so bits unused by an opcode still toggle
	function automatic pkt_item_t random_beat();
		pkt_item_t b;
		b.opcode = 2'($urandom_range(0, 3));
		b.first_header_byte = 8'($urandom);
		b.socket_uid = $urandom;
		b.packet_length = 16'($urandom);
		b.direction = 1'($urandom);
		b.src_high = rand64();
		b.src_low = rand64();
		b.dst_high = rand64();
		b.dst_low = rand64();
		b.entry_index = 3'($urandom_range(0, TABLE_DEPTH - 1));
		b.entry_word = rand64();
		b.entry_prefix_len = 8'($urandom);
		return b;
	endfunction

	// address inside a random live IPv4 entry, or anywhere
	function automatic logic [31:0] v4_target(input bit hit);
		int          i;
		logic [31:0] m;
		if (!hit || searched(gen_v4_cnt) == 0)
			return $urandom;
		i = $urandom_range(0, searched(gen_v4_cnt) - 1);
		m = gen_v4_rule[i][63:32];
		return (gen_v4_rule[i][31:0] & m) | ($urandom & ~m);
	endfunction

	function automatic logic [127:0] v6_target(input bit hit);
		int           i;
		logic [127:0] m;
		if (!hit || searched(gen_v6_cnt) == 0)
			return {rand64(), rand64()};
		i = $urandom_range(0, searched(gen_v6_cnt) - 1);
		m = prefix_mask(gen_v6_plen[i]);
		return ({gen_v6_hi[i], gen_v6_lo[i]} & m) | ({rand64(), rand64()} & ~m);
	endfunction

	function automatic pkt_item_t make_packet(input logic [3:0] ver, input bit src_hit,
	                                          input bit dst_hit);
		pkt_item_t b;
		b = random_beat();
		b.opcode = OP_PACKET;
		b.first_header_byte[7:4] = ver;
		if (ver == VER_V4) begin
			b.src_low[31:0] = v4_target(src_hit);
			b.dst_low[31:0] = v4_target(dst_hit);
		end else if (ver == VER_V6) begin
			{b.src_high, b.src_low} = v6_target(src_hit);
			{b.dst_high, b.dst_low} = v6_target(dst_hit);
		end
		return b;
	endfunction

	// mostly clean CIDR entries; now and then an IPv4 net with bits outside its mask
	function automatic pkt_item_t make_write(input logic [1:0] op, input int idx);
		pkt_item_t   b;
		int          len;
		logic [31:0] m;
		logic [31:0] net;
		b = random_beat();
		b.opcode = op;
		b.entry_index = 3'(idx);
		if (op == OP_WR_V4) begin
			len = $urandom_range(0, 32);
			m = ~({32{1'b1}} >> len);
			net = $urandom;
			if ($urandom_range(0, 7) != 0)
				net &= m;
			b.entry_word = {m, net};
		end else if (op == OP_WR_V6_HI) begin
			b.entry_prefix_len = ($urandom_range(0, 9) == 0) ? 8'($urandom_range(129, 255))
			                                                 : 8'($urandom_range(0, 128));
		end
		return b;
	endfunction

	function automatic void queue_beat(input pkt_item_t b);
		case (b.opcode)
			OP_WR_V4: gen_v4_rule[b.entry_index] = b.entry_word;
			OP_WR_V6_HI: begin
				gen_v6_hi[b.entry_index] = b.entry_word;
				gen_v6_plen[b.entry_index] = b.entry_prefix_len;
			end
			OP_WR_V6_LO: gen_v6_lo[b.entry_index] = b.entry_word;
			default: ;
		endcase
		if (b.opcode != OP_PACKET || b.first_header_byte[7:4] == VER_V4 ||
		    b.first_header_byte[7:4] == VER_V6)
			real_items++;
		beats_to_send.push_back(b);
	endfunction

	// mostly no gap, a few short ones, rarely a long one
	function automatic int idle_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		if (r < 88)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 10);
		return $urandom_range(20, 40);
	endfunction

	task automatic report_mismatch(input string what, input logic [63:0] got,
	                               input logic [63:0] want);
		if (mismatches < MAX_REPORTS)
			$display("%0t: %s: got %h, expected %h", $time, what, got, want);
		mismatches++;
	endtask

	// ------------------------------------------------------------------
	// Driver: presents queued beats; the predictor runs on each accepted beat.
	// in_valid is assigned once per edge so a back-to-back beat never glitches.
	// ------------------------------------------------------------------
	int in_gap = 0;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			in_gap = 0;
		end else begin
			if (in_valid && !in_stall)
				filter_beat(cur);
			if (!(in_valid && in_stall)) begin
				if (in_gap > 0) begin
					in_gap--;
					in_valid <= 1'b0;
				end else if (beats_to_send.size() != 0) begin
					cur <= beats_to_send.pop_front();
					in_valid <= 1'b1;
					in_gap = in_gaps_on ? idle_len() : 0;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// ------------------------------------------------------------------
	// Monitor: takes events in order and checks each field; stalls at random.
	// ------------------------------------------------------------------
	int stall_left = 0;

	always @(posedge clk or negedge arst_n) begin
		meter_event_t got;
		meter_event_t want;
		int           n;
		if (!arst_n) begin
			out_stall <= 1'b0;
			stall_left = 0;
		end else begin
			if (out_valid && !out_stall) begin
				got = {is_v6, event_uid, event_bytes, event_direction,
				       event_src_high, event_src_low, event_dst_high, event_dst_low};
				if (due_events.size() == 0) begin
					report_mismatch("event with none due, uid", got.uid, '0);
				end else begin
					want = due_events.pop_front();
					if (got.is_v6 !== want.is_v6)
						report_mismatch("is_v6", got.is_v6, want.is_v6);
					if (got.uid !== want.uid)
						report_mismatch("event_uid", got.uid, want.uid);
					if (got.bytes !== want.bytes)
						report_mismatch("event_bytes", got.bytes, want.bytes);
					if (got.dir !== want.dir)
						report_mismatch("event_direction", got.dir, want.dir);
					if (got.src_high !== want.src_high)
						report_mismatch("event_src_high", got.src_high, want.src_high);
					if (got.src_low !== want.src_low)
						report_mismatch("event_src_low", got.src_low, want.src_low);
					if (got.dst_high !== want.dst_high)
						report_mismatch("event_dst_high", got.dst_high, want.dst_high);
					if (got.dst_low !== want.dst_low)
						report_mismatch("event_dst_low", got.dst_low, want.dst_low);
				end
			end
			if (stall_left > 0) begin
				stall_left--;
				out_stall <= 1'b1;
			end else begin
				n = out_stalls_on ? idle_len() : 0;
				out_stall <= (n > 0);
				stall_left = (n > 0) ? n - 1 : 0;
			end
		end
	end

	// Watchdog: any beat on either channel or a config access counts as progress.
	int quiet_cycles = 0;

	always @(posedge clk) begin
		if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall) ||
		    (psel && penable)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("tb failed");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	// ------------------------------------------------------------------
	// Sequencer
	// ------------------------------------------------------------------

	// Wait until every queued beat is in and every due event is out, then let the
	// chain flush: writes and dropped packets still travel through it silently.
	task automatic wait_drained();
		do
			@(negedge clk);
		while (beats_to_send.size() != 0 || in_valid || due_events.size() != 0);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	// Setup then access cycle; the count lands at the edge with pready high.
	// Upper data bits are noise, the register keeps only its low nibble.
	task automatic write_count(input logic reg_idx, input logic [CNT_W-1:0] val);
		logic [31:0] noise;
		noise = $urandom;
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {reg_idx, 2'b00};
		pwdata <= {noise[31:CNT_W], val};
		@(posedge clk);
		penable <= 1'b1;
		do
			@(posedge clk);
		while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		if (reg_idx == REG_V4_CNT) begin
			flt_v4_cnt = val;
			gen_v4_cnt = val;
		end else begin
			flt_v6_cnt = val;
			gen_v6_cnt = val;
		end
		@(negedge clk);
	endtask

	task automatic set_counts(input logic [CNT_W-1:0] v4, input logic [CNT_W-1:0] v6);
		write_count(REG_V4_CNT, v4);
		write_count(REG_V6_CNT, v6);
	endtask

	logic [CNT_W-1:0] phase_v4_cnt [RANDOM_PHASES] = '{4'd8, 4'd1, 4'd12, 4'd3,
	                                                   4'd0, 4'd8, 4'd5, 4'd15};
	logic [CNT_W-1:0] phase_v6_cnt [RANDOM_PHASES] = '{4'd8, 4'd9, 4'd2, 4'd0,
	                                                   4'd8, 4'd15, 4'd4, 4'd7};

	initial begin
		pkt_item_t b;
		int        r;
		int        target;

		repeat (RESET_CYCLES) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Empty tables searched: every IPv4/IPv6 packet meters, other versions never do.
		set_counts('0, '0);
		b = make_packet(VER_V4, 1'b0, 1'b0);
		b.first_header_byte[3:0] = 4'h0;
		b.socket_uid = '0;
		b.packet_length = '0;
		b.direction = 1'b0;
		b.src_high = '1;                      // ignored upper bits set
		b.src_low[63:32] = '1;
		b.dst_low = '0;
		queue_beat(b);
		b = make_packet(VER_V6, 1'b0, 1'b0);
		b.first_header_byte[3:0] = 4'hf;
		b.socket_uid = '1;
		b.packet_length = '1;
		b.direction = 1'b1;
		b.src_high = '1;
		b.src_low = '1;
		b.dst_high = '0;
		b.dst_low = '0;
		queue_beat(b);
		queue_beat(make_packet(4'h0, 1'b0, 1'b0));
		queue_beat(make_packet(4'h5, 1'b0, 1'b0));
		queue_beat(make_packet(4'hf, 1'b0, 1'b0));

		// Fill every entry of both tables before any count covers them.
		// Entry 7 matches everything (mask 0 / prefix 0), entry 6 is exact
		// (full mask / prefix past 128), plus prefixes at the half boundary.
		for (int i = 0; i < TABLE_DEPTH; i++) begin
			b = make_write(OP_WR_V4, i);
			if (i == 7)
				b.entry_word = '0;
			else if (i == 6)
				b.entry_word[63:32] = '1;
			queue_beat(b);
			b = make_write(OP_WR_V6_HI, i);
			case (i)
				7: b.entry_prefix_len = 8'd0;
				6: b.entry_prefix_len = 8'd200;
				5: b.entry_prefix_len = 8'd128;
				0: b.entry_prefix_len = 8'd64;
				1: b.entry_prefix_len = 8'd65;
				2: b.entry_prefix_len = 8'd1;
				default: ;
			endcase
			queue_beat(b);
			queue_beat(make_write(OP_WR_V6_LO, i));
		end
		wait_drained();

		// Match-all entries out of reach: each end hit or missed on purpose.
		set_counts(4'd6, 4'd6);
		for (int k = 0; k < 4; k++) begin
			queue_beat(make_packet(VER_V4, k[0], k[1]));
			queue_beat(make_packet(VER_V6, k[0], k[1]));
		end
		wait_drained();

		// Counts past the table size reach the match-all entries: all dropped.
		set_counts('1, '1);
		queue_beat(make_packet(VER_V4, 1'b0, 1'b0));
		queue_beat(make_packet(VER_V6, 1'b0, 1'b0));
		wait_drained();

		// Random phases. Idling pattern rotates: both sides, sender only,
		// receiver only, none. Each phase ends fully drained before new counts.
		for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
			in_gaps_on = (ph % 4) < 2;
			out_stalls_on = (ph % 4) == 0 || (ph % 4) == 2;
			set_counts(phase_v4_cnt[ph], phase_v6_cnt[ph]);
			target = real_items + PHASE_ITEMS;
			while (real_items < target) begin
				r = $urandom_range(0, 99);
				if (r < 64)
					queue_beat(make_packet($urandom_range(0, 1) ? VER_V6 : VER_V4,
					                       $urandom_range(0, 99) < 70,
					                       $urandom_range(0, 99) < 70));
				else if (r < 70)
					queue_beat(make_packet(4'($urandom_range(0, 15)), 1'b0, 1'b0));
				else if (r < 78)
					queue_beat(make_write(OP_WR_V4, $urandom_range(0, TABLE_DEPTH - 1)));
				else if (r < 86)
					queue_beat(make_write(OP_WR_V6_HI, $urandom_range(0, TABLE_DEPTH - 1)));
				else if (r < 94)
					queue_beat(make_write(OP_WR_V6_LO, $urandom_range(0, TABLE_DEPTH - 1)));
				else
					queue_beat(random_beat());
			end
			wait_drained();
		end

		if (mismatches == 0)
			$display("tb passed");
		else
			$display("tb failed");
		$finish;
	end

endmodule
